@@ rtl/core/local_max_3x3_detector_macros.svh @@
// Assertion macros used by the verdict stage of the local maximum detector.
// Each macro expects clk and rst_n to be visible where it is expanded.
`ifndef LOCAL_MAX_3X3_DETECTOR_MACROS_SVH
`define LOCAL_MAX_3X3_DETECTOR_MACROS_SVH

// Same-cycle implication.
`define LMD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define LMD_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/lmd_pkg.sv @@
`default_nettype none

package lmd_pkg;

    localparam int MAX_COLS = 1024;
    localparam int MAX_ROWS = 1024;
    localparam int PIX_W    = 16;
    localparam int COL_W    = $clog2(MAX_COLS);
    localparam int ROW_W    = $clog2(MAX_ROWS);
    localparam int CNT_W    = 11;
    localparam int LINE_W   = 2 * PIX_W;

    // Verdict queue: one input can release at most RUN_MAX verdicts.
    localparam int RUN_MAX  = 4;
    localparam int VQ_DEPTH = 16;
    localparam int VQ_AW    = $clog2(VQ_DEPTH);
    localparam int VQ_CW    = VQ_AW + 1;
    localparam int RUN_W    = $clog2(RUN_MAX + 1);

    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;

    // Register indexes (paddr[2]).
    localparam logic REG_ROW_COUNT = 1'b0;
    localparam logic REG_COL_COUNT = 1'b1;

    typedef logic [PIX_W-1:0]  pix_t;
    typedef logic [ROW_W-1:0]  row_t;
    typedef logic [COL_W-1:0]  col_t;
    typedef logic [CNT_W-1:0]  cnt_t;
    typedef logic [LINE_W-1:0] line_t;
    typedef logic [VQ_CW-1:0]  vq_cnt_t;

    // Window element [k][m]: k = 0 is row r-2, m = 0 is column c-2.
    typedef pix_t [2:0][2:0] win_t;

    typedef struct packed {
        logic valid;
        pix_t pixel;
        row_t row;
        col_t col;
    } s1_t;

    typedef struct packed {
        logic valid;
        row_t row;
        col_t col;
    } s2_t;

    typedef struct packed {
        logic s1_busy;
        logic s2_busy;
    } pipe_stat_t;

    typedef struct packed {
        row_t row_index;
        col_t col_index;
        logic is_max;
        logic last_of_run;
        logic frame_done;
    } vrd_t;

    // Zero acts as one, values above the limit saturate.
    function automatic cnt_t clamp_count(input cnt_t value, input int limit);
        cnt_t res;
        if (value == '0)
        begin
            res = cnt_t'(1);
        end
        else if (int'(value) > limit)
        begin
            res = cnt_t'(limit);
        end
        else
        begin
            res = value;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/lmd_pix_if.sv @@
`default_nettype none

interface lmd_pix_if;
    import lmd_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [PIX_W-1:0] pixel_value;

    modport source (output valid, output pixel_value, input ready);
    modport sink   (input valid, input pixel_value, output ready);
endinterface

`default_nettype wire

@@ rtl/core/lmd_vrd_if.sv @@
`default_nettype none

interface lmd_vrd_if;
    import lmd_pkg::*;

    logic       valid;
    logic       ready;
    row_t       row_index;
    col_t       col_index;
    logic       is_max;
    logic       last_of_run;
    logic       frame_done;

    modport source (output valid, output row_index, output col_index, output is_max,
                    output last_of_run, output frame_done, input ready);
    modport sink   (input valid, input row_index, input col_index, input is_max,
                    input last_of_run, input frame_done, output ready);
endinterface

`default_nettype wire

@@ rtl/core/lmd_ram.sv @@
`default_nettype none

module lmd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // A read of the entry being written returns the old contents.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ rtl/core/lmd_window.sv @@
`default_nettype none

module lmd_window (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire lmd_pkg::s1_t       beat_in,
    output lmd_pkg::s2_t            s2_out,
    output lmd_pkg::win_t           win_out,
    output lmd_pkg::pipe_stat_t     stat
);
    import lmd_pkg::*;

    s1_t   s1_reg;
    s2_t   s2_reg;
    win_t  win_reg;
    logic  fwd_reg;
    line_t fwd_data_reg;
    line_t ram_rdata;
    line_t line_word;
    line_t wr_word;
    pix_t  prev_pix;
    pix_t  older_pix;
    logic  fwd_next;

    // Each word holds the previous row in the upper half, the older row below.
    lmd_ram #(
        .WIDTH (LINE_W),
        .DEPTH (MAX_COLS)
    ) u_line_ram (
        .clk   (clk),
        .we    (s1_reg.valid),
        .waddr (s1_reg.col),
        .wdata (wr_word),
        .re    (beat_in.valid),
        .raddr (beat_in.col),
        .rdata (ram_rdata)
    );

    // With a single column, back-to-back beats hit the same entry; the
    // write-back of the older beat is forwarded past the RAM.
    assign fwd_next  = beat_in.valid && s1_reg.valid && (beat_in.col == s1_reg.col);
    assign line_word = fwd_reg ? fwd_data_reg : ram_rdata;
    assign prev_pix  = line_word[LINE_W-1:PIX_W];
    assign older_pix = line_word[PIX_W-1:0];
    assign wr_word   = {s1_reg.pixel, prev_pix};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg  <= '0;
            s2_reg  <= '0;
            fwd_reg <= 1'b0;
        end
        else
        begin
            s1_reg       <= beat_in;
            s2_reg.valid <= s1_reg.valid;
            s2_reg.row   <= s1_reg.row;
            s2_reg.col   <= s1_reg.col;
            fwd_reg      <= fwd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fwd_data_reg <= wr_word;
        if (s1_reg.valid)
        begin
            for (int k = 0; k < 3; k++)
            begin
                win_reg[k][0] <= win_reg[k][1];
                win_reg[k][1] <= win_reg[k][2];
            end
            win_reg[0][2] <= older_pix;
            win_reg[1][2] <= prev_pix;
            win_reg[2][2] <= s1_reg.pixel;
        end
    end

    assign s2_out        = s2_reg;
    assign win_out       = win_reg;
    assign stat.s1_busy  = s1_reg.valid;
    assign stat.s2_busy  = s2_reg.valid;

endmodule

`default_nettype wire

@@ rtl/core/lmd_verdict.sv @@
`default_nettype none

`include "local_max_3x3_detector_macros.svh"

module lmd_verdict (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire lmd_pkg::s2_t       s2_in,
    input  wire lmd_pkg::win_t      win_in,
    input  wire lmd_pkg::cnt_t      rows,
    input  wire lmd_pkg::cnt_t      cols,
    output lmd_pkg::vq_cnt_t        vq_count,
    lmd_vrd_if.source               vrd_out
);
    import lmd_pkg::*;

    // Strict maximum test of window element [ki][kj] against its in-frame
    // neighbours; up/dn/lf/rt tell which sides exist in the frame.
    function automatic logic judge(input win_t w, input int ki, input int kj,
                                   input logic up, input logic dn,
                                   input logic lf, input logic rt);
        logic res;
        logic ok;
        int   ni;
        int   nj;
        res = 1'b1;
        for (int di = -1; di <= 1; di++)
        begin
            for (int dj = -1; dj <= 1; dj++)
            begin
                ni = ki + di;
                nj = kj + dj;
                if (!(di == 0 && dj == 0) && ni >= 0 && ni <= 2 && nj >= 0 && nj <= 2)
                begin
                    ok = (di != -1 || up) && (di != 1 || dn) &&
                         (dj != -1 || lf) && (dj != 1 || rt);
                    if (ok && ($signed(w[ni][nj]) >= $signed(w[ki][kj])))
                    begin
                        res = 1'b0;
                    end
                end
            end
        end
        return res;
    endfunction

    vrd_t                   vq_mem_reg [VQ_DEPTH];
    logic [VQ_AW-1:0]       wr_ptr_reg;
    logic [VQ_AW-1:0]       rd_ptr_reg;
    vq_cnt_t                count_reg;
    vq_cnt_t                count_next;

    logic                   row_gt0;
    logic                   col_gt0;
    logic                   col_last;
    logic                   row_last;
    logic [RUN_MAX-1:0]     en;
    logic [RUN_MAX-1:0]     last;
    logic [RUN_W-1:0]       pre [RUN_MAX];
    logic [RUN_W-1:0]       push_n;
    row_t                   ci [RUN_MAX];
    col_t                   cj [RUN_MAX];
    vrd_t                   entry [RUN_MAX];
    logic                   pop;

    assign row_gt0  = (s2_in.row != '0);
    assign col_gt0  = (s2_in.col != '0);
    assign col_last = (cnt_t'(s2_in.col) == cols - cnt_t'(1));
    assign row_last = (cnt_t'(s2_in.row) == rows - cnt_t'(1));

    // Released in order (r-1,c-1), (r-1,c), (r,c-1), (r,c).
    assign en[0] = s2_in.valid && row_gt0 && col_gt0;
    assign en[1] = s2_in.valid && row_gt0 && col_last;
    assign en[2] = s2_in.valid && row_last && col_gt0;
    assign en[3] = s2_in.valid && row_last && col_last;

    assign ci[0] = s2_in.row - row_t'(1);
    assign ci[1] = s2_in.row - row_t'(1);
    assign ci[2] = s2_in.row;
    assign ci[3] = s2_in.row;
    assign cj[0] = s2_in.col - col_t'(1);
    assign cj[1] = s2_in.col;
    assign cj[2] = s2_in.col - col_t'(1);
    assign cj[3] = s2_in.col;

    always_comb
    begin
        pre[0] = '0;
        for (int k = 1; k < RUN_MAX; k++)
        begin
            pre[k] = pre[k-1] + RUN_W'(en[k-1]);
        end
        push_n = pre[RUN_MAX-1] + RUN_W'(en[RUN_MAX-1]);
        last[RUN_MAX-1] = en[RUN_MAX-1];
        for (int k = RUN_MAX - 2; k >= 0; k--)
        begin
            last[k] = en[k] && ((en >> (k + 1)) == '0);
        end
    end

    always_comb
    begin
        for (int k = 0; k < RUN_MAX; k++)
        begin
            entry[k].row_index   = ci[k];
            entry[k].col_index   = cj[k];
            entry[k].is_max      = judge(win_in, 1 + k / 2, 1 + k % 2,
                                         ci[k] != '0,
                                         cnt_t'(ci[k]) != rows - cnt_t'(1),
                                         cj[k] != '0,
                                         cnt_t'(cj[k]) != cols - cnt_t'(1));
            entry[k].last_of_run = last[k];
            entry[k].frame_done  = (cnt_t'(ci[k]) == rows - cnt_t'(1)) &&
                                   (cnt_t'(cj[k]) == cols - cnt_t'(1));
        end
    end

    assign pop        = vrd_out.valid && vrd_out.ready;
    assign count_next = count_reg + vq_cnt_t'(push_n) - vq_cnt_t'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + VQ_AW'(push_n);
            rd_ptr_reg <= rd_ptr_reg + VQ_AW'(pop);
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < RUN_MAX; k++)
        begin
            if (en[k])
            begin
                vq_mem_reg[wr_ptr_reg + VQ_AW'(pre[k])] <= entry[k];
            end
        end
    end

    assign vq_count            = count_reg;
    assign vrd_out.valid       = (count_reg != '0);
    assign vrd_out.row_index   = vq_mem_reg[rd_ptr_reg].row_index;
    assign vrd_out.col_index   = vq_mem_reg[rd_ptr_reg].col_index;
    assign vrd_out.is_max      = vq_mem_reg[rd_ptr_reg].is_max;
    assign vrd_out.last_of_run = vq_mem_reg[rd_ptr_reg].last_of_run;
    assign vrd_out.frame_done  = vq_mem_reg[rd_ptr_reg].frame_done;

    `LMD_ASSERT_IMP(a_vq_no_overflow, s2_in.valid,
                    (VQ_CW+1)'(count_reg) + (VQ_CW+1)'(push_n) <= (VQ_CW+1)'(VQ_DEPTH),
                    "verdict queue overflow")
    `LMD_ASSERT_IMP(a_done_is_last, vrd_out.valid && vrd_out.frame_done,
                    vrd_out.last_of_run, "frame end verdict not last of its run")
    `LMD_ASSERT_NXT(a_vq_stays_empty, count_reg == '0 && !s2_in.valid,
                    count_reg == '0, "verdict appeared without a pipeline beat")

endmodule

`default_nettype wire

@@ rtl/core/local_max_3x3_detector.sv @@
// Streaming 3x3 strict local-maximum detector. Samples enter in raster order
// at one beat per clock while ready is high; every position yields one
// verdict, issued as soon as its last in-frame neighbour has arrived, so a
// row end or a sample of the last row can release up to four verdicts. Past
// the s1 and s2 registers, verdicts enter a 16-entry queue that drains one
// verdict a cycle while the output is ready; the input holds ready low only
// while that queue lacks room for the worst case of the samples in flight,
// as when the receiver stalls or in the last row, where a sample can release
// two verdicts. The two previous rows sit in one 1024 x 32 RAM, read when a
// sample is taken and written back the next cycle; no clearing pass is needed
// after reset. Registers: row_count at 0x0, col_count at 0x4 (zero reads as
// one, larger than 1024 saturates); writing either one restarts the frame.
`default_nettype none

module local_max_3x3_detector (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [lmd_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [lmd_pkg::PDATA_W-1:0]  pwdata,
    output logic      [lmd_pkg::PDATA_W-1:0]  prdata,
    output logic                              pready,
    lmd_pix_if.sink                           pix_in,
    lmd_vrd_if.source                         vrd_out
);
    import lmd_pkg::*;

    cnt_t        rows_reg;
    cnt_t        cols_reg;
    row_t        row_reg;
    col_t        col_reg;
    logic        cfg_wr;
    logic        accept;
    s1_t         beat;
    s2_t         s2;
    win_t        win;
    pipe_stat_t  stat;
    vq_cnt_t     vq_count;
    logic [1:0]  busy_n;
    logic [VQ_CW:0] credit;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb
    begin
        unique case (paddr[2])
            REG_ROW_COUNT: prdata = PDATA_W'(rows_reg);
            REG_COL_COUNT: prdata = PDATA_W'(cols_reg);
            default:       prdata = '0;
        endcase
    end

    // Room for the worst-case verdicts of every beat in flight plus this one.
    assign busy_n = 2'(stat.s1_busy) + 2'(stat.s2_busy);
    assign credit = (VQ_CW+1)'(vq_count) + (VQ_CW+1)'(busy_n) * (VQ_CW+1)'(RUN_MAX);
    assign pix_in.ready = (credit <= (VQ_CW+1)'(VQ_DEPTH - RUN_MAX));
    assign accept = pix_in.valid && pix_in.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg <= cnt_t'(1);
            cols_reg <= cnt_t'(1);
            row_reg  <= '0;
            col_reg  <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[2])
                REG_ROW_COUNT: rows_reg <= clamp_count(pwdata[CNT_W-1:0], MAX_ROWS);
                REG_COL_COUNT: cols_reg <= clamp_count(pwdata[CNT_W-1:0], MAX_COLS);
                default:       rows_reg <= rows_reg;
            endcase
            row_reg <= '0;
            col_reg <= '0;
        end
        else if (accept)
        begin
            if (cnt_t'(col_reg) == cols_reg - cnt_t'(1))
            begin
                col_reg <= '0;
                if (cnt_t'(row_reg) == rows_reg - cnt_t'(1))
                begin
                    row_reg <= '0;
                end
                else
                begin
                    row_reg <= row_reg + row_t'(1);
                end
            end
            else
            begin
                col_reg <= col_reg + col_t'(1);
            end
        end
    end

    assign beat.valid = accept;
    assign beat.pixel = pix_in.pixel_value;
    assign beat.row   = row_reg;
    assign beat.col   = col_reg;

    lmd_window u_window (
        .clk     (clk),
        .rst_n   (rst_n),
        .beat_in (beat),
        .s2_out  (s2),
        .win_out (win),
        .stat    (stat)
    );

    lmd_verdict u_verdict (
        .clk      (clk),
        .rst_n    (rst_n),
        .s2_in    (s2),
        .win_in   (win),
        .rows     (rows_reg),
        .cols     (cols_reg),
        .vq_count (vq_count),
        .vrd_out  (vrd_out)
    );

endmodule

`default_nettype wire

@@ tb/tb_local_max_3x3_detector.sv @@
typedef logic signed [lmd_pkg::PIX_W-1:0] sample_t;

// Tracks the frame position and the last three rows, and keeps the verdicts
// that the accepted samples are due to release, oldest first.
class verdict_board;
    int rows;
    int cols;
    int cur_row;
    int cur_col;
    int unsigned errors;
    sample_t line_buf [3][lmd_pkg::MAX_COLS];
    lmd_pkg::vrd_t verdict_q [$];

    function new();
        rows = 1;
        cols = 1;
        cur_row = 0;
        cur_col = 0;
        errors = 0;
    endfunction

    function int pending();
        return verdict_q.size();
    endfunction

    // Only the low 11 bits count; zero acts as one and larger values saturate.
    function void set_reg(logic reg_sel, logic [31:0] word);
        int v;
        v = int'(word[lmd_pkg::CNT_W-1:0]);
        if (reg_sel == lmd_pkg::REG_ROW_COUNT)
        begin
            rows = (v == 0) ? 1 : ((v > lmd_pkg::MAX_ROWS) ? lmd_pkg::MAX_ROWS : v);
        end
        else
        begin
            cols = (v == 0) ? 1 : ((v > lmd_pkg::MAX_COLS) ? lmd_pkg::MAX_COLS : v);
        end
        cur_row = 0;
        cur_col = 0;
    endfunction

    // Strict maximum over the in-frame 8-connected neighbours.
    function bit judge(int i, int j);
        sample_t centre;
        int ni;
        int nj;
        centre = line_buf[i % 3][j];
        for (int di = -1; di <= 1; di++)
        begin
            for (int dj = -1; dj <= 1; dj++)
            begin
                ni = i + di;
                nj = j + dj;
                if ((di != 0 || dj != 0) && ni >= 0 && ni < rows && nj >= 0 && nj < cols)
                begin
                    if (line_buf[ni % 3][nj] >= centre)
                    begin
                        return 1'b0;
                    end
                end
            end
        end
        return 1'b1;
    endfunction

    function void note_pixel(sample_t v);
        int r;
        int c;
        int n;
        int vi [4];
        int vj [4];
        lmd_pkg::vrd_t vd;
        r = cur_row;
        c = cur_col;
        n = 0;
        line_buf[r % 3][c] = v;
        if (r >= 1 && c >= 1)
        begin
            vi[n] = r - 1;
            vj[n] = c - 1;
            n++;
        end
        if (r >= 1 && c == cols - 1)
        begin
            vi[n] = r - 1;
            vj[n] = c;
            n++;
        end
        if (r == rows - 1 && c >= 1)
        begin
            vi[n] = r;
            vj[n] = c - 1;
            n++;
        end
        if (r == rows - 1 && c == cols - 1)
        begin
            vi[n] = r;
            vj[n] = c;
            n++;
        end
        for (int k = 0; k < n; k++)
        begin
            vd.row_index   = lmd_pkg::row_t'(vi[k]);
            vd.col_index   = lmd_pkg::col_t'(vj[k]);
            vd.is_max      = judge(vi[k], vj[k]);
            vd.last_of_run = (k == n - 1);
            vd.frame_done  = (vi[k] == rows - 1 && vj[k] == cols - 1);
            verdict_q.push_back(vd);
        end
        cur_col++;
        if (cur_col >= cols)
        begin
            cur_col = 0;
            cur_row++;
            if (cur_row >= rows)
            begin
                cur_row = 0;
            end
        end
    endfunction

    function void check_verdict(lmd_pkg::vrd_t got);
        lmd_pkg::vrd_t want;
        if (verdict_q.size() == 0)
        begin
            $error("unexpected verdict for row %0d col %0d", got.row_index, got.col_index);
            errors++;
            return;
        end
        want = verdict_q.pop_front();
        if (got.row_index !== want.row_index)
        begin
            $error("row_index: expected %0d, actual %0d", want.row_index, got.row_index);
            errors++;
        end
        if (got.col_index !== want.col_index)
        begin
            $error("col_index: expected %0d, actual %0d", want.col_index, got.col_index);
            errors++;
        end
        if (got.is_max !== want.is_max)
        begin
            $error("is_max: expected %0d, actual %0d", want.is_max, got.is_max);
            errors++;
        end
        if (got.last_of_run !== want.last_of_run)
        begin
            $error("last_of_run: expected %0d, actual %0d", want.last_of_run, got.last_of_run);
            errors++;
        end
        if (got.frame_done !== want.frame_done)
        begin
            $error("frame_done: expected %0d, actual %0d", want.frame_done, got.frame_done);
            errors++;
        end
    endfunction
endclass

module tb_local_max_3x3_detector;
    timeunit 1ns;
    timeprecision 1ps;

    import lmd_pkg::*;

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    lmd_pix_if pix ();
    lmd_vrd_if vrd ();

    local_max_3x3_detector DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .pix_in  (pix),
        .vrd_out (vrd)
    );

    verdict_board sb = new();

    int unsigned src_idle_pct = 0;
    int unsigned snk_idle_pct = 0;
    int unsigned hold_left = 0;
    logic        hold_req = 1'b0;
    vrd_t        seen;

    always #6 clk = ~clk;

    // Receiver: checks every accepted beat and drives ready, with a long
    // hold-off when one is requested.
    always @(posedge clk)
    begin
        if (rst_n && vrd.valid && vrd.ready)
        begin
            seen.row_index   = vrd.row_index;
            seen.col_index   = vrd.col_index;
            seen.is_max      = vrd.is_max;
            seen.last_of_run = vrd.last_of_run;
            seen.frame_done  = vrd.frame_done;
            sb.check_verdict(seen);
        end
        if (hold_req)
        begin
            hold_req  <= 1'b0;
            hold_left <= 300;
            vrd.ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            vrd.ready <= 1'b0;
        end
        else
        begin
            vrd.ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    function automatic sample_t rand_pixel();
        sample_t v;
        case ($urandom_range(3))
            0: v = sample_t'($urandom);
            1: v = sample_t'(int'($urandom_range(6)) - 3);
            2: v = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
            default: v = sample_t'($urandom_range(255));
        endcase
        return v;
    endfunction

    task automatic send_pixel(input sample_t v);
        while ($urandom_range(99) < src_idle_pct)
        begin
            pix.valid <= 1'b0;
            @(posedge clk);
        end
        pix.valid       <= 1'b1;
        pix.pixel_value <= v;
        do
        begin
            @(posedge clk);
        end
        while (!pix.ready);
        sb.note_pixel(v);
    endtask

    task automatic drain();
        pix.valid <= 1'b0;
        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // A sample that releases nothing may still be in the pipeline once the
    // last verdict is out, so keep waiting after the drain.
    task automatic wait_quiet();
        drain();
        repeat (24) @(posedge clk);
    endtask

    task automatic apb_write(input logic reg_sel, input logic [31:0] word);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= word;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apb_read(input logic reg_sel, output logic [31:0] word);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {reg_sel, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        word = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_count(input logic reg_sel, input logic [31:0] word);
        logic [31:0] rd;
        int          want;
        wait_quiet();
        apb_write(reg_sel, word);
        sb.set_reg(reg_sel, word);
        want = (reg_sel == REG_ROW_COUNT) ? sb.rows : sb.cols;
        apb_read(reg_sel, rd);
        if (rd !== 32'(want))
        begin
            $error("prdata: expected %0d, actual %0d", want, rd);
            sb.errors++;
        end
    endtask

    task automatic send_frames(input int n);
        for (int k = 0; k < n; k++)
        begin
            send_pixel(rand_pixel());
        end
    endtask

    // Mostly whole frames of small random sizes; now and then a frame is cut
    // short by a register write, or the sender waits for the output to drain.
    task automatic run_mix(input int n_items);
        int          sent;
        int          len;
        int          fsize;
        logic [31:0] word;
        sent = 0;
        while (sent < n_items)
        begin
            word = $urandom;
            if ($urandom_range(1))
            begin
                word[31:CNT_W] = '0;
            end
            word[CNT_W-1:0] = CNT_W'($urandom_range(1, 6));
            set_count(REG_ROW_COUNT, word);
            word = $urandom;
            word[CNT_W-1:0] = CNT_W'($urandom_range(1, 8));
            set_count(REG_COL_COUNT, word);
            fsize = sb.rows * sb.cols;
            case ($urandom_range(7))
                0: len = (fsize > 1) ? $urandom_range(1, fsize - 1) : 1;
                1: len = 2 * fsize;
                default: len = fsize;
            endcase
            for (int k = 0; k < len; k++)
            begin
                if ($urandom_range(39) == 0)
                begin
                    drain();
                end
                send_pixel(rand_pixel());
            end
            sent += len;
        end
    endtask

    initial
    begin
        clk             = 1'b0;
        rst_n           = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        pix.valid       = 1'b0;
        pix.pixel_value = '0;
        vrd.ready       = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // A 1x1 frame is always a maximum.
        send_pixel(16'sh7FFF);
        send_pixel(16'sh8000);
        send_pixel(16'sh0000);

        // Zero rows acts as one; equal neighbours defeat each other.
        set_count(REG_ROW_COUNT, 32'h0000_0000);
        set_count(REG_COL_COUNT, 32'h0000_0003);
        send_pixel(16'sd5);
        send_pixel(16'sd5);
        send_pixel(-16'sd1);
        send_pixel(16'sh8000);
        send_pixel(16'sh7FFF);
        send_pixel(16'sh7FFF);

        set_count(REG_ROW_COUNT, 32'h0000_0003);
        send_pixel(16'sd1);
        send_pixel(16'sd2);
        send_pixel(16'sd3);
        send_pixel(16'sd4);
        send_pixel(16'sd100);
        send_pixel(16'sd6);
        send_pixel(16'sd7);
        send_pixel(16'sd8);
        send_pixel(16'sd9);

        // Part of a frame, then a write that restarts it; upper bits ignored.
        send_pixel(16'sh8000);
        send_pixel(16'sh7FFF);
        send_pixel(16'sh8001);
        send_pixel(16'sh7FFE);
        set_count(REG_COL_COUNT, 32'hFFFF_F803);
        send_frames(9);

        src_idle_pct = 35;
        snk_idle_pct = 78;
        run_mix(60);
        src_idle_pct = 78;
        snk_idle_pct = 35;
        run_mix(60);
        src_idle_pct = 0;
        snk_idle_pct = 0;
        run_mix(60);

        // Long receiver hold-off while the sender keeps streaming.
        set_count(REG_ROW_COUNT, 32'h0000_0006);
        set_count(REG_COL_COUNT, 32'h0000_0005);
        hold_req <= 1'b1;
        send_frames(60);

        // Largest sizes, reached by saturation and by the exact value.
        set_count(REG_COL_COUNT, 32'h0000_0001);
        set_count(REG_ROW_COUNT, 32'h0000_07FF);
        send_frames(20);
        set_count(REG_ROW_COUNT, 32'h0000_0001);
        set_count(REG_COL_COUNT, 32'h0000_0400);
        send_frames(20);

        wait_quiet();
        if (sb.errors == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

    initial
    begin
        #5ms;
        $display("simulation failed");
        $finish;
    end
endmodule
